// ----- design/spli_pkg.sv -----
package spli_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 10;
  localparam int RANK_W   = 6;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_READOUT = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ENTRY     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

endpackage

// ----- design/spli_ram.sv -----
module spli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/sorted_priority_list_insert_unit.sv -----
// Insert: each held entry compared is read, then compared; each entry moved up is read,
// then written one rank up; the value is stored and the result loaded into the result
// register once it is free, so an output stall delays it. Readout: each entry is read,
// then presented once the result register is free; an empty list gives a single beat.
// One request is worked on at a time. Reset (rst_n low, synchronous) empties the list;
// the entry memory is not cleared, since only held ranks are read.
module sorted_priority_list_insert_unit
  import spli_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] priority_value, [15:10] zero
  input  logic        in_tuser,   // [0] req_type
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] entry_value, [15:10] rank
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);

  // The controller walks the memory one entry at a time: one state issues
  // the read, the next uses the registered read data.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SRCH  = 9'b000000010,  // issue read of the candidate rank
    S_CMP   = 9'b000000100,  // compare stored entry with the new value
    S_SHIFT = 9'b000001000,  // read the entry below the free slot, or store value
    S_MOVE  = 9'b000010000,  // write that entry one rank up
    S_EMIT  = 9'b000100000,  // hand the single insert/empty result over
    S_RDRD  = 9'b001000000,  // readout: issue read of the next rank
    S_RDOUT = 9'b010000000,  // readout: present the entry
    S_SPARE = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;     // search position, later the insert rank
  logic [CNT_W-1:0]   j_r, j_nxt;         // free slot while moving entries up
  logic [VALUE_W-1:0] val_r, val_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [RANK_W-1:0]  res_rank_r, res_rank_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [RANK_W-1:0]  out_rank_r, out_rank_nxt;
  logic               out_last_r, out_last_nxt;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0]   idx_inc, j_dec;
  logic               slot_free, is_full;

  spli_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_inc   = idx_r + 1'b1;
  assign j_dec     = j_r - 1'b1;
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rank_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    j_nxt          = j_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_rank_nxt   = res_rank_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_rank_nxt   = out_rank_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = j_r[IDX_W-1:0];
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = idx_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          val_nxt = in_tdata[VALUE_W-1:0];
          idx_nxt = '0;
          if (in_tuser == REQ_INSERT) begin
            state_nxt = S_SRCH;
          end else if (count_r == '0) begin
            res_status_nxt = ST_EMPTY;
            res_rank_nxt   = '0;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_RDRD;
          end
        end
      end
      S_SRCH: begin
        if (idx_r == count_r) begin
          // Every held entry is smaller: the value goes at the tail.
          if (is_full) begin
            res_status_nxt = ST_FULL;
            res_rank_nxt   = '0;
            state_nxt      = S_EMIT;
          end else begin
            j_nxt     = count_r;
            state_nxt = S_SHIFT;
          end
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (ram_rdata == val_r) begin
          res_status_nxt = ST_DUPLICATE;
          res_rank_nxt   = RANK_W'(idx_r);
          state_nxt      = S_EMIT;
        end else if (ram_rdata > val_r) begin
          if (is_full) begin
            res_status_nxt = ST_FULL;
            res_rank_nxt   = '0;
            state_nxt      = S_EMIT;
          end else begin
            j_nxt     = count_r;
            state_nxt = S_SHIFT;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRCH;
        end
      end
      S_SHIFT: begin
        if (j_r == idx_r) begin
          ram_we         = 1'b1;
          ram_wdata      = val_r;
          count_nxt      = count_r + 1'b1;
          res_status_nxt = ST_INSERTED;
          res_rank_nxt   = RANK_W'(idx_r);
          state_nxt      = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_dec[IDX_W-1:0];
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        // Read and write addresses differ by one, so no forwarding is needed.
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        j_nxt     = j_dec;
        state_nxt = S_SHIFT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = '0;
          out_rank_nxt   = res_rank_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RDRD: begin
        ram_re    = 1'b1;
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        // The read data register holds while the output side stalls.
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ENTRY;
          out_value_nxt  = ram_rdata;
          out_rank_nxt   = RANK_W'(idx_r);
          out_last_nxt   = (idx_inc == count_r);
          idx_nxt        = idx_inc;
          state_nxt      = (idx_inc == count_r) ? S_IDLE : S_RDRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    j_r          <= j_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_rank_r   <= res_rank_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_rank_r   <= out_rank_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> count_r == $past(count_r) + 1'b1)
    else $error("entry count changed by other than one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  a_single_results_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_ENTRY) |-> out_last_r && (out_value_r == '0))
    else $error("single-beat result without last or with nonzero value");
`endif

endmodule
